[src/tsp_pkg.sv]
`timescale 1ns / 1ps

package tsp_pkg;

    // longest message, in bytes, before further bytes count as malformed
    localparam int unsigned MAX_MESSAGE_BYTES = 65535;

    // item kinds on the input side
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // parser phases
    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_LENHI = 2'd1;
    localparam logic [1:0] PH_LENLO = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    // byte roles
    localparam logic [2:0] ROLE_TYPE    = 3'd0;
    localparam logic [2:0] ROLE_LENHI   = 3'd1;
    localparam logic [2:0] ROLE_LENLO   = 3'd2;
    localparam logic [2:0] ROLE_VALUE   = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    // message status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    localparam logic [7:0] MAX_RECORDS_RESET = 8'd16;

    // one result item
    typedef struct packed {
        logic [7:0]  record_count;
        logic [1:0]  parse_status;
        logic        record_done;
        logic [15:0] value_index;
        logic [15:0] record_len;
        logic [7:0]  record_type;
        logic [7:0]  record_index;
        logic [7:0]  data_out;
        logic [15:0] byte_offset;
        logic [2:0]  byte_role;
    } result_t;

endpackage

[src/tlv_stream_parser_core.sv]
`timescale 1ns / 1ps

// Streaming parser for type-length-value records: one type byte, a big-endian
// 16-bit length and that many value bytes. Each input item is a message byte
// (tuser 0) or an end-of-message marker (tuser 1); every item yields exactly one
// result item, registered in the cycle after it is accepted. A byte result tags the byte
// with its role, record index, type, length and value position; the end result
// (tuser 1) carries the message length, record count and status, and readies
// the parser for the next message. The parser takes one item every cycle: the
// phase update is a single step of logic feeding the output register, and the
// input stalls only while that register holds a result not yet taken.
// max_records may be written only while no item is in flight.

module tlv_stream_parser_core
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        max_records_we,
    input  logic [7:0]  max_records_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [2:0] byte_role, [18:3] byte_offset,
                                        // [26:19] data_out, [34:27] record_index,
                                        // [42:35] record_type, [58:43] record_len,
                                        // [74:59] value_index, [75] record_done,
                                        // [77:76] parse_status, [85:78] record_count,
                                        // [87:86] zero
    output logic        m_axis_tuser    // [0] is_end
);

    localparam logic [16:0] MSG_LIMIT = 17'(MAX_MESSAGE_BYTES);

    logic [7:0]  max_records_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  records_seen_reg, records_seen_next;
    logic [7:0]  current_type_reg, current_type_next;
    logic [15:0] current_len_reg, current_len_next;
    logic [15:0] value_pos_reg, value_pos_next;
    logic [16:0] message_pos_reg, message_pos_next;
    logic        pending_overflow_reg, pending_overflow_next;
    logic [1:0]  error_code_reg, error_code_next;

    logic        out_valid_reg;
    logic        is_end_reg, is_end_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic [15:0] offset_sat;
    logic [15:0] len_full;
    logic [15:0] value_pos_inc;

    // input stalls only while a result waits
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign offset_sat    = message_pos_reg[16] ? 16'hFFFF : message_pos_reg[15:0];
    assign len_full      = {current_len_reg[15:8], s_axis_tdata};
    assign value_pos_inc = value_pos_reg + 16'd1;

    // phase update and result for one item
    always_comb
    begin
        phase_next            = phase_reg;
        records_seen_next     = records_seen_reg;
        current_type_next     = current_type_reg;
        current_len_next      = current_len_reg;
        value_pos_next        = value_pos_reg;
        message_pos_next      = message_pos_reg;
        pending_overflow_next = pending_overflow_reg;
        error_code_next       = error_code_reg;
        result_next           = '0;
        is_end_next           = 1'b0;

        if (s_axis_tuser == OP_END)
        begin
            // end of message: report, then clear the message state
            is_end_next              = 1'b1;
            result_next.byte_offset  = offset_sat;
            result_next.record_count = records_seen_reg;
            if (error_code_reg != ST_OK)
                result_next.parse_status = error_code_reg;
            else if (phase_reg != PH_TYPE)
                result_next.parse_status = ST_MALFORMED;
            else
                result_next.parse_status = ST_OK;
            phase_next            = PH_TYPE;
            records_seen_next     = '0;
            current_type_next     = '0;
            current_len_next      = '0;
            value_pos_next        = '0;
            message_pos_next      = '0;
            pending_overflow_next = 1'b0;
            error_code_next       = ST_OK;
        end
        else
        begin
            result_next.byte_offset  = offset_sat;
            result_next.data_out     = s_axis_tdata;
            result_next.record_index = records_seen_reg;

            // message too long
            if (error_code_reg == ST_OK && message_pos_reg >= MSG_LIMIT)
                error_code_next = ST_MALFORMED;

            if (error_code_next != ST_OK)
            begin
                result_next.byte_role = ROLE_IGNORED;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TYPE:
                    begin
                        result_next.byte_role   = ROLE_TYPE;
                        result_next.record_type = s_axis_tdata;
                        current_type_next       = s_axis_tdata;
                        current_len_next        = '0;
                        value_pos_next          = '0;
                        pending_overflow_next   = (records_seen_reg >= max_records_reg);
                        phase_next              = PH_LENHI;
                    end
                    PH_LENHI:
                    begin
                        result_next.byte_role   = ROLE_LENHI;
                        result_next.record_type = current_type_reg;
                        current_len_next        = {s_axis_tdata, 8'h00};
                        phase_next              = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        result_next.byte_role   = ROLE_LENLO;
                        result_next.record_type = current_type_reg;
                        result_next.record_len  = len_full;
                        current_len_next        = len_full;
                        if (pending_overflow_reg)
                        begin
                            error_code_next       = ST_TOO_MANY;
                            pending_overflow_next = 1'b0;
                            phase_next            = PH_TYPE;
                        end
                        else if (len_full == 16'd0)
                        begin
                            result_next.record_done = 1'b1;
                            records_seen_next       = records_seen_reg + 8'd1;
                            phase_next              = PH_TYPE;
                        end
                        else
                        begin
                            value_pos_next = '0;
                            phase_next     = PH_VALUE;
                        end
                    end
                    PH_VALUE:
                    begin
                        result_next.byte_role   = ROLE_VALUE;
                        result_next.record_type = current_type_reg;
                        result_next.record_len  = current_len_reg;
                        result_next.value_index = value_pos_reg;
                        value_pos_next          = value_pos_inc;
                        if (value_pos_inc >= current_len_reg)
                        begin
                            result_next.record_done = 1'b1;
                            records_seen_next       = records_seen_reg + 8'd1;
                            phase_next              = PH_TYPE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_TYPE;
                    end
                endcase
            end

            // message position saturates
            if (message_pos_reg != 17'h1FFFF)
                message_pos_next = message_pos_reg + 17'd1;

            result_next.parse_status = error_code_next;
            result_next.record_count = records_seen_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_records_reg <= MAX_RECORDS_RESET;
        else if (max_records_we)
            max_records_reg <= max_records_wdata;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_TYPE;
            records_seen_reg     <= '0;
            current_type_reg     <= '0;
            current_len_reg      <= '0;
            value_pos_reg        <= '0;
            message_pos_reg      <= '0;
            pending_overflow_reg <= 1'b0;
            error_code_reg       <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            records_seen_reg     <= records_seen_next;
            current_type_reg     <= current_type_next;
            current_len_reg      <= current_len_next;
            value_pos_reg        <= value_pos_next;
            message_pos_reg      <= message_pos_next;
            pending_overflow_reg <= pending_overflow_next;
            error_code_reg       <= error_code_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            is_end_reg <= is_end_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg};
    assign m_axis_tuser  = is_end_reg;

endmodule

[test/tlv_parse_checker.sv]
`timescale 1ns / 1ps

module tlv_parse_checker
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_data,
    input  logic        in_user,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [87:0] out_data,
    input  logic        out_user,
    output int unsigned mismatches,
    output int unsigned tags_waiting
);

    // one expected result: end flag plus the packed fields
    typedef struct packed {
        logic    is_end;
        result_t res;
    } byte_tag_t;

    byte_tag_t tag_q[$];

    // own copy of the parser state and the record limit
    logic [7:0]  max_rec;
    logic [1:0]  phase;
    logic [7:0]  recs;
    logic [7:0]  cur_type;
    logic [15:0] cur_len;
    logic [15:0] val_pos;
    logic [16:0] msg_pos;
    logic        ovf_pending;
    logic [1:0]  err;

    function automatic void restart_message();
        phase       = PH_TYPE;
        recs        = '0;
        cur_type    = '0;
        cur_len     = '0;
        val_pos     = '0;
        msg_pos     = '0;
        ovf_pending = 1'b0;
        err         = ST_OK;
    endfunction

    // works out the tag for one item and advances the state
    task automatic tag_item(input logic op, input logic [7:0] b, output byte_tag_t t);
        logic [1:0] status;
        t = '0;
        t.res.byte_offset = (msg_pos > 17'h0FFFF) ? 16'hFFFF : msg_pos[15:0];
        if (op == OP_END)
        begin
            t.is_end = 1'b1;
            status = err;
            // ending anywhere but before a type byte is a cut-short message
            if (status == ST_OK && phase != PH_TYPE)
                status = ST_MALFORMED;
            t.res.parse_status = status;
            t.res.record_count = recs;
            restart_message();
        end
        else
        begin
            t.res.data_out     = b;
            t.res.record_index = recs;
            // over-long message
            if (err == ST_OK && msg_pos >= MAX_MESSAGE_BYTES)
                err = ST_MALFORMED;
            if (err != ST_OK)
                t.res.byte_role = ROLE_IGNORED;
            else
            begin
                case (phase)
                    PH_TYPE:
                    begin
                        t.res.byte_role   = ROLE_TYPE;
                        t.res.record_type = b;
                        cur_type    = b;
                        cur_len     = '0;
                        val_pos     = '0;
                        ovf_pending = (recs >= max_rec);
                        phase       = PH_LENHI;
                    end
                    PH_LENHI:
                    begin
                        t.res.byte_role   = ROLE_LENHI;
                        t.res.record_type = cur_type;
                        cur_len = {b, 8'h00};
                        phase   = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        cur_len = {cur_len[15:8], b};
                        t.res.byte_role   = ROLE_LENLO;
                        t.res.record_type = cur_type;
                        t.res.record_len  = cur_len;
                        if (ovf_pending)
                        begin
                            err         = ST_TOO_MANY;
                            ovf_pending = 1'b0;
                            phase       = PH_TYPE;
                        end
                        else if (cur_len == 16'd0)
                        begin
                            t.res.record_done = 1'b1;
                            recs  = recs + 8'd1;
                            phase = PH_TYPE;
                        end
                        else
                        begin
                            val_pos = '0;
                            phase   = PH_VALUE;
                        end
                    end
                    default:
                    begin
                        t.res.byte_role   = ROLE_VALUE;
                        t.res.record_type = cur_type;
                        t.res.record_len  = cur_len;
                        t.res.value_index = val_pos;
                        val_pos = val_pos + 16'd1;
                        if (val_pos >= cur_len)
                        begin
                            t.res.record_done = 1'b1;
                            recs  = recs + 8'd1;
                            phase = PH_TYPE;
                        end
                    end
                endcase
            end
            // position saturates at the top of its range
            if (msg_pos != 17'h1FFFF)
                msg_pos = msg_pos + 17'd1;
            t.res.parse_status = err;
            t.res.record_count = recs;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // compare taken results, then tag newly accepted items
    always @(posedge clk or negedge rst_n)
    begin : watch
        byte_tag_t want;
        result_t   got;
        if (!rst_n)
        begin
            tag_q.delete();
            restart_message();
            max_rec      = MAX_RECORDS_RESET;
            mismatches   = 0;
            tags_waiting = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tag_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t ns: result item with none expected", $time);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = tag_q.pop_front();
                    got  = out_data[85:0];
                    check_field("is_end", want.is_end, out_user);
                    check_field("byte_role", want.res.byte_role, got.byte_role);
                    check_field("byte_offset", want.res.byte_offset, got.byte_offset);
                    check_field("data_out", want.res.data_out, got.data_out);
                    check_field("record_index", want.res.record_index, got.record_index);
                    check_field("record_type", want.res.record_type, got.record_type);
                    check_field("record_len", want.res.record_len, got.record_len);
                    check_field("value_index", want.res.value_index, got.value_index);
                    check_field("record_done", want.res.record_done, got.record_done);
                    check_field("parse_status", want.res.parse_status, got.parse_status);
                    check_field("record_count", want.res.record_count, got.record_count);
                    check_field("tdata padding", 64'd0, out_data[87:86]);
                end
            end
            if (in_valid && in_ready)
            begin
                tag_item(in_user, in_data, want);
                tag_q.push_back(want);
            end
            if (cfg_we)
                max_rec = cfg_wdata;
            tags_waiting = tag_q.size();
        end
    end

endmodule

[test/tlv_stream_parser_core_test.sv]
`timescale 1ns / 1ps

module tlv_stream_parser_core_test;
    import tsp_pkg::*;

    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS = 150;

    logic        clk;
    logic        rst_n;
    logic        max_records_we;
    logic [7:0]  max_records_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;

    int unsigned mismatches;
    int unsigned tags_waiting;

    bit          idle_on;
    bit          hold_req;
    logic [7:0]  cur_max;
    logic [7:0]  msg_q[$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    tlv_stream_parser_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_records_we    (max_records_we),
        .max_records_wdata (max_records_wdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser)
    );

    tlv_parse_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (max_records_we),
        .cfg_wdata    (max_records_wdata),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_data      (s_axis_tdata),
        .in_user      (s_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_user     (m_axis_tuser),
        .mismatches   (mismatches),
        .tags_waiting (tags_waiting)
    );

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left     = 0;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // offer one item, with an optional gap first; returns on a falling edge
    task automatic send_item(input logic op, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i])
            send_item(OP_BYTE, msg_q[i]);
        send_item(OP_END, 8'($urandom));
    endtask

    task automatic add_record(input int unsigned len);
        msg_q.push_back(8'($urandom));
        msg_q.push_back(len[15:8]);
        msg_q.push_back(len[7:0]);
        repeat (len) msg_q.push_back(8'($urandom));
    endtask

    // mostly short values, now and then one past 255 bytes
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 4);
        if (r < 92)
            return $urandom_range(5, 24);
        if (r < 98)
            return $urandom_range(25, 80);
        return $urandom_range(256, 300);
    endfunction

    task automatic send_random_message(input bit allow_idle);
        int unsigned kind;
        int unsigned n;
        int unsigned cut;
        msg_q.delete();
        idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            // well-formed records
            n = $urandom_range(0, 6);
            repeat (n) add_record(pick_len());
        end
        else if (kind == 6)
        begin
            // cut short at a random byte
            n = $urandom_range(1, 4);
            repeat (n) add_record(pick_len());
            cut = $urandom_range(1, msg_q.size() - 1);
            while (msg_q.size() > cut)
                void'(msg_q.pop_back());
        end
        else if (kind == 7)
        begin
            // noise
            repeat ($urandom_range(1, 24)) msg_q.push_back(8'($urandom));
        end
        else if (kind == 8)
        begin
            // past the record limit when it is below 8, else one to three records; then trailing bytes
            n = (cur_max < 8) ? cur_max + $urandom_range(1, 2) : $urandom_range(1, 3);
            repeat (n) add_record($urandom_range(0, 3));
            repeat ($urandom_range(0, 5)) msg_q.push_back(8'($urandom));
        end
        send_message();
    endtask

    // wait until every expected result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tags_waiting != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_max_records(input logic [7:0] v);
        drain();
        max_records_we    <= 1'b1;
        max_records_wdata <= v;
        @(negedge clk);
        max_records_we    <= 1'b0;
        cur_max = v;
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [7:0]  limits [8];
        int unsigned start_count;
        int unsigned sent;
        limits = '{8'd255, 8'd0, 8'd3, 8'd1, 8'd16, 8'd5, 8'd2, 8'd7};
        rst_n             = 1'b0;
        max_records_we    = 1'b0;
        max_records_wdata = 8'd0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = 8'd0;
        s_axis_tuser      = OP_BYTE;
        cur_max           = MAX_RECORDS_RESET;
        idle_on           = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero-length record, then a record with extreme bytes, at the reset limit
        msg_q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
        send_message();

        // no records allowed: first header is too many, next byte ignored
        set_max_records(8'd0);
        msg_q = '{8'hA5, 8'h00, 8'h01, 8'h5A};
        send_message();

        // header cut short, value cut short, cut short with overflow pending, empty
        set_max_records(8'd1);
        msg_q = '{8'h11, 8'h00};
        send_message();
        msg_q = '{8'h22, 8'h00, 8'h02, 8'h33};
        send_message();
        msg_q = '{8'h01, 8'h00, 8'h00, 8'h02, 8'h00};
        send_message();
        msg_q.delete();
        send_message();

        // random messages under several limits
        sent = 0;
        for (int p = 0; p < 8; p++)
        begin
            set_max_records(p == 4 ? 8'($urandom) : limits[p]);
            start_count = sent;
            if (p == 0)
            begin
                // 256 empty records against the highest limit
                idle_on = 1'b1;
                msg_q.delete();
                repeat (256) add_record(0);
                send_message();
                sent += msg_q.size() + 1;
            end
            if (p == 2)
                hold_req = 1'b1;
            while (sent - start_count < PHASE_ITEMS)
            begin
                send_random_message(p != 7);
                sent += msg_q.size() + 1;
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (5) @(negedge clk);
        if (mismatches == 0 && tags_waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
